[hw/rtl/stsplit_pkg.sv]
// Shared constants and types for the square tile splitter.
`default_nettype none

package stsplit_pkg;

    // Coordinate width default
    localparam int COORD_BITS_DEF = 13;

    // Fixed register widths
    localparam int TILE_SIDE_BITS  = 13;
    localparam int AREA_LIMIT_BITS = 27;
    localparam int CFG_DATA_BITS   = 27;
    localparam int CFG_ADDR_BITS   = 2;

    // Register indexes on the configuration port
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_SPLIT_MODE = 2'd0,
        CFG_TILE_SIDE  = 2'd1,
        CFG_AREA_LIMIT = 2'd2
    } cfg_index_t;

    // Split modes
    localparam logic MODE_FIXED    = 1'b0;
    localparam logic MODE_MIN_AREA = 1'b1;

    // Command codes carried in tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // Register reset values
    localparam logic                       SPLIT_MODE_RST = MODE_MIN_AREA;
    localparam logic [TILE_SIDE_BITS-1:0]  TILE_SIDE_RST  = 13'd128;
    localparam logic [AREA_LIMIT_BITS-1:0] AREA_LIMIT_RST = 27'd16384;

endpackage

`default_nettype wire

[hw/rtl/square_tile_splitter_core.sv]
// Square tile splitter: cuts a loaded rectangle into square tiles, one per next command.
//
// Input beats arrive on s_axis: tuser carries the command (start or next), tdata the
// rectangle edges used by a start. A start loads the rectangle and gives no output beat;
// each next gives one tile on m_axis, with tlast marking the tile that completes the
// rectangle. A next with no rectangle loaded gives nothing.
// Configuration registers (split mode, tile side, area limit) are written through cfg_we,
// cfg_addr and cfg_wdata; split mode acts on the next beat, tile side on the next start,
// area limit on the next start or strip reload. A tile shows on m_axis the cycle after
// its command beat. Throughput: one beat per cycle unless m_axis stalls. Each command
// is handled in a single pass of cursor adds and compares plus one coordinate multiply
// for the region area, all between the state registers and the output register.
// Stall: the output register holds a tile while m_axis_tready is low; s_axis_tready
// stays high as long as that register is empty or being drained in the same cycle.
// Reset: rst_n clears the output valid, drops any loaded rectangle and restores the
// register defaults (min-area mode, tile side 128, area limit 16384).
`default_nettype none

module square_tile_splitter_core
    import stsplit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0]             cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0]             cfg_wdata,
    // command stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata: rect_left, rect_top, rect_right, rect_bottom, zero pad
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // tuser: command
    input  wire logic                                 s_axis_tuser,
    // tile stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // tdata: tile_left, tile_top, tile_right, tile_bottom, zero pad
    output logic [((4*COORD_BITS+7)/8)*8-1:0]         m_axis_tdata,
    // tlast: last_tile
    output logic                                      m_axis_tlast
);

    localparam int CB      = COORD_BITS;
    localparam int SUM_W   = COORD_BITS + 1;
    localparam int AREA_W  = 2 * COORD_BITS;
    localparam int CMP_W   = (AREA_W > AREA_LIMIT_BITS) ? AREA_W : AREA_LIMIT_BITS;
    localparam int SIDE_W  = (COORD_BITS > TILE_SIDE_BITS) ? COORD_BITS : TILE_SIDE_BITS;
    localparam int TDATA_W = ((4*COORD_BITS+7)/8)*8;

    // Configuration registers
    logic                       split_mode_reg;
    logic [TILE_SIDE_BITS-1:0]  tile_side_reg;
    logic [AREA_LIMIT_BITS-1:0] area_limit_reg;

    // Region state
    logic [CB-1:0] region_left_reg,   region_left_next;
    logic [CB-1:0] region_top_reg,    region_top_next;
    logic [CB-1:0] region_right_reg,  region_right_next;
    logic [CB-1:0] region_bottom_reg, region_bottom_next;
    logic [CB-1:0] cursor_x_reg,      cursor_x_next;
    logic [CB-1:0] cursor_y_reg,      cursor_y_next;
    logic [CB-1:0] square_side_reg,   square_side_next;
    logic [AREA_W-1:0]          area_reg;
    logic [AREA_LIMIT_BITS-1:0] area_lim_reg, area_lim_next;
    logic          busy_reg,          busy_next;
    logic          area_load;

    // Output register
    logic              m_valid_reg;
    logic [TDATA_W-1:0] m_data_reg;
    logic              m_last_reg;

    // Handshake
    logic accept;
    logic out_load;

    // Input fields
    logic          in_cmd;
    logic [CB-1:0] il, it, ir, ib;
    logic [CB-1:0] in_w, in_h, in_short;

    // Working values from the current region
    logic [CB-1:0]    cx, cy, rw, rh, shortest, rem_w, rem_h;
    logic [SUM_W-1:0] cxh, cyw;
    logic             below_limit;

    // Multiplier
    logic [CB-1:0]     mul_a, mul_b;
    logic [AREA_W-1:0] area_prod;

    // Fixed mode working values
    logic [CB-1:0]    fn, fx, fy;
    logic [SUM_W-1:0] cxn, cyn;
    logic             last_col, last_row;
    logic [TILE_SIDE_BITS-1:0] ts_eff;

    // Tile being produced
    logic [CB-1:0] t_l, t_t, t_r, t_b;
    logic          t_last;
    logic [TDATA_W-1:0] t_data;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // Unpack the command beat
    assign in_cmd   = s_axis_tuser;
    assign il       = s_axis_tdata[0*CB +: CB];
    assign it       = s_axis_tdata[1*CB +: CB];
    assign ir       = s_axis_tdata[2*CB +: CB];
    assign ib       = s_axis_tdata[3*CB +: CB];
    assign in_w     = ir - il;
    assign in_h     = ib - it;
    assign in_short = (in_w < in_h) ? in_w : in_h;
    assign ts_eff   = (tile_side_reg == '0) ? TILE_SIDE_BITS'(1) : tile_side_reg;

    // Pull a stray cursor back to the region corner
    assign cx = (cursor_x_reg < region_left_reg || cursor_x_reg >= region_right_reg)
                ? region_left_reg : cursor_x_reg;
    assign cy = (cursor_y_reg < region_top_reg || cursor_y_reg >= region_bottom_reg)
                ? region_top_reg : cursor_y_reg;
    assign rw       = region_right_reg - region_left_reg;
    assign rh       = region_bottom_reg - region_top_reg;
    assign shortest = (rw < rh) ? rw : rh;
    assign rem_w    = region_right_reg - cx;
    assign rem_h    = region_bottom_reg - cy;
    assign cxh      = SUM_W'(cx) + SUM_W'(rh);
    assign cyw      = SUM_W'(cy) + SUM_W'(rw);
    assign below_limit = CMP_W'(area_reg) < CMP_W'(area_lim_reg);

    // Fixed mode tile placement
    assign fn       = (square_side_reg == '0 || square_side_reg > shortest)
                      ? shortest : square_side_reg;
    assign cxn      = SUM_W'(cx) + SUM_W'(fn);
    assign cyn      = SUM_W'(cy) + SUM_W'(fn);
    assign last_col = cxn >= SUM_W'(region_right_reg);
    assign last_row = cyn >= SUM_W'(region_bottom_reg);
    assign fx       = last_col ? region_right_reg - fn : cx;
    assign fy       = last_row ? region_bottom_reg - fn : cy;

    // Region area for the small-region test
    assign area_prod = AREA_W'(mul_a) * AREA_W'(mul_b);

    // Decide the tile and the next state for one beat
    always_comb
    begin
        region_left_next   = region_left_reg;
        region_top_next    = region_top_reg;
        region_right_next  = region_right_reg;
        region_bottom_next = region_bottom_reg;
        cursor_x_next      = cursor_x_reg;
        cursor_y_next      = cursor_y_reg;
        square_side_next   = square_side_reg;
        area_lim_next      = area_lim_reg;
        busy_next          = busy_reg;
        area_load          = 1'b0;
        mul_a              = in_w;
        mul_b              = in_h;
        out_load           = 1'b0;
        t_l                = cx;
        t_t                = cy;
        t_r                = region_right_reg;
        t_b                = region_bottom_reg;
        t_last             = 1'b0;

        if (accept)
        begin
            if (in_cmd == CMD_START)
            begin
                if (ir <= il || ib <= it)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    // Load a new rectangle
                    region_left_next   = il;
                    region_top_next    = it;
                    region_right_next  = ir;
                    region_bottom_next = ib;
                    cursor_x_next      = il;
                    cursor_y_next      = it;
                    square_side_next   = in_short;
                    if (split_mode_reg == MODE_FIXED &&
                        SIDE_W'(ts_eff) < SIDE_W'(in_short))
                    begin
                        square_side_next = CB'(ts_eff);
                    end
                    area_load     = 1'b1;
                    area_lim_next = area_limit_reg;
                    busy_next     = 1'b1;
                end
            end
            else if (busy_reg)
            begin
                out_load      = 1'b1;
                cursor_x_next = cx;
                cursor_y_next = cy;
                if (split_mode_reg == MODE_FIXED)
                begin
                    // Row-major tiles, last row and column flush with the edges
                    t_l    = fx;
                    t_t    = fy;
                    t_r    = CB'(SUM_W'(fx) + SUM_W'(fn));
                    t_b    = CB'(SUM_W'(fy) + SUM_W'(fn));
                    t_last = last_col && last_row;
                    if (last_col)
                    begin
                        cursor_x_next = region_left_reg;
                        if (last_row)
                            busy_next = 1'b0;
                        else
                            cursor_y_next = CB'(cyn);
                    end
                    else
                    begin
                        cursor_x_next = CB'(cxn);
                    end
                end
                else if (rw == rh)
                begin
                    // Square region goes out whole
                    t_l       = region_left_reg;
                    t_t       = region_top_reg;
                    t_last    = 1'b1;
                    busy_next = 1'b0;
                end
                else if (rw > rh)
                begin
                    t_t = region_top_reg;
                    if (cxh >= SUM_W'(region_right_reg))
                    begin
                        if (below_limit)
                        begin
                            // Overlap the last square with the right edge
                            t_l       = region_right_reg - rh;
                            t_last    = 1'b1;
                            busy_next = 1'b0;
                        end
                        else
                        begin
                            // Reload the remainder strip, now tall or square
                            region_left_next = cx;
                            square_side_next = rem_w;
                            mul_a            = rem_w;
                            mul_b            = rh;
                            area_load        = 1'b1;
                            area_lim_next    = area_limit_reg;
                            t_l              = cx;
                            cursor_y_next    = region_top_reg;
                            if (rem_w == rh)
                            begin
                                t_last    = 1'b1;
                                busy_next = 1'b0;
                            end
                            else
                            begin
                                t_b           = region_top_reg + rem_w;
                                cursor_y_next = region_top_reg + rem_w;
                            end
                        end
                    end
                    else
                    begin
                        t_l           = cx;
                        t_r           = CB'(cxh);
                        cursor_x_next = CB'(cxh);
                    end
                end
                else
                begin
                    t_l = region_left_reg;
                    if (cyw >= SUM_W'(region_bottom_reg))
                    begin
                        if (below_limit)
                        begin
                            // Overlap the last square with the bottom edge
                            t_t       = region_bottom_reg - rw;
                            t_last    = 1'b1;
                            busy_next = 1'b0;
                        end
                        else
                        begin
                            // Reload the remainder strip, now wide or square
                            region_top_next  = cy;
                            square_side_next = rem_h;
                            mul_a            = rw;
                            mul_b            = rem_h;
                            area_load        = 1'b1;
                            area_lim_next    = area_limit_reg;
                            t_t              = cy;
                            cursor_x_next    = region_left_reg;
                            if (rem_h == rw)
                            begin
                                t_last    = 1'b1;
                                busy_next = 1'b0;
                            end
                            else
                            begin
                                t_r           = region_left_reg + rem_h;
                                cursor_x_next = region_left_reg + rem_h;
                            end
                        end
                    end
                    else
                    begin
                        t_t           = cy;
                        t_b           = CB'(cyw);
                        cursor_y_next = CB'(cyw);
                    end
                end
            end
        end
    end

    // Pack the tile edges, zero pad on top
    always_comb
    begin
        t_data              = '0;
        t_data[0*CB +: CB]  = t_l;
        t_data[1*CB +: CB]  = t_t;
        t_data[2*CB +: CB]  = t_r;
        t_data[3*CB +: CB]  = t_b;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_mode_reg <= SPLIT_MODE_RST;
            tile_side_reg  <= TILE_SIDE_RST;
            area_limit_reg <= AREA_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SPLIT_MODE: split_mode_reg <= cfg_wdata[0];
                CFG_TILE_SIDE:  tile_side_reg  <= cfg_wdata[TILE_SIDE_BITS-1:0];
                CFG_AREA_LIMIT: area_limit_reg <= cfg_wdata[AREA_LIMIT_BITS-1:0];
                default:        split_mode_reg <= split_mode_reg;
            endcase
        end
    end

    // Hold region state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_left_reg   <= '0;
            region_top_reg    <= '0;
            region_right_reg  <= '0;
            region_bottom_reg <= '0;
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            square_side_reg   <= '0;
            area_reg          <= '0;
            area_lim_reg      <= '0;
            busy_reg          <= 1'b0;
        end
        else
        begin
            region_left_reg   <= region_left_next;
            region_top_reg    <= region_top_next;
            region_right_reg  <= region_right_next;
            region_bottom_reg <= region_bottom_next;
            cursor_x_reg      <= cursor_x_next;
            cursor_y_reg      <= cursor_y_next;
            square_side_reg   <= square_side_next;
            area_lim_reg      <= area_lim_next;
            busy_reg          <= busy_next;
            if (area_load)
                area_reg <= area_prod;
        end
    end

    // Advance output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (accept)
            m_valid_reg <= out_load;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    // Capture the tile beat
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= t_data;
            m_last_reg <= t_last;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/stsplit_checker.sv]
// Port-level checks for the square tile splitter, bound to the top level.
`default_nettype none

module stsplit_checker
    import stsplit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    input wire logic                              m_axis_tlast
);

    localparam int CB = COORD_BITS;

    logic [CB-1:0] tl, tt, tr, tb;

    assign tl = m_axis_tdata[0*CB +: CB];
    assign tt = m_axis_tdata[1*CB +: CB];
    assign tr = m_axis_tdata[2*CB +: CB];
    assign tb = m_axis_tdata[3*CB +: CB];

    // Stalled tile beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("tile beat changed while stalled");

    // Empty output register never blocks commands
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("command stalled with empty output");

    // A start beat never produces a tile
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_START |=> !m_axis_tvalid)
        else $error("tile after start command");

    // Every tile is a nonempty square
    a_square: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (tr > tl) && (tb > tt) && (tr - tl == tb - tt))
        else $error("tile is not a nonempty square");

endmodule

bind square_tile_splitter_core stsplit_checker #(
    .COORD_BITS (COORD_BITS)
) u_stsplit_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
